@@ rtl/fkjt_pkg.sv @@
// Shared types, constants and helpers for the joint tree kinematics block.
// Used by fkjt_cordic, forward_kinematics_joint_tree and the testbench; depends on nothing.
`default_nettype none
package fkjt_pkg;

   localparam int MAX_JOINTS_DEF = 32;

   // Fixed-point constants
   localparam logic signed [33:0] ONE_Q30        = 34'sd1073741824;
   localparam logic signed [33:0] CORDIC_K       = 34'sd652032874;
   localparam logic signed [34:0] DEG_TO_RAD_Q46 = 35'sd9595048166;
   localparam logic signed [17:0] HALF_TURN      = 18'sd23040;
   localparam logic signed [17:0] QUARTER_TURN   = 18'sd11520;
   localparam logic signed [17:0] FULL_TURN      = 18'sd46080;
   localparam logic signed [15:0] AXIS_ONE       = 16'sd16384;
   localparam logic [4:0]         LAST_ITER      = 5'd29;

   // CORDIC datapath width (x, y, z)
   localparam int ZW = 34;

   typedef struct packed {
      logic               has_parent;
      logic [4:0]         parent_index;
      logic               revolute;
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic signed [31:0] offset_z;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic signed [15:0] angle;
      logic               last_joint;
   } req_type;

   typedef struct packed {
      logic signed [31:0] r00;
      logic signed [31:0] r01;
      logic signed [31:0] r02;
      logic signed [31:0] r10;
      logic signed [31:0] r11;
      logic signed [31:0] r12;
      logic signed [31:0] r20;
      logic signed [31:0] r21;
      logic signed [31:0] r22;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } rsp_type;

   // Result of the sine/cosine unit
   typedef struct packed {
      logic               done;
      logic signed [31:0] sin;
      logic signed [31:0] cos;
   } sincos_type;

   typedef enum logic [1:0] {
      COR_IDLE,
      COR_ANGLE,
      COR_ITER,
      COR_FINISH
   } cor_phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_RODR,
      ST_RCLAMP,
      ST_LOAD,
      ST_COMPOSE,
      ST_ROOT,
      ST_WRITE,
      ST_OUTPUT
   } fkjt_state_type;

   // atan(2^-i) in Q2.30
   function automatic logic [31:0] atan_q30(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:    v = 32'd843314857;
         5'd1:    v = 32'd497837829;
         5'd2:    v = 32'd263043837;
         5'd3:    v = 32'd133525159;
         5'd4:    v = 32'd67021687;
         5'd5:    v = 32'd33543516;
         5'd6:    v = 32'd16775851;
         5'd7:    v = 32'd8388437;
         5'd8:    v = 32'd4194283;
         5'd9:    v = 32'd2097149;
         default: v = 32'd1 << (5'd30 - i);
      endcase
      return v;
   endfunction

   // Clamp to [-2^30, 2^30]
   function automatic logic signed [31:0] clamp_q30(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd1073741824)
         r = 32'sd1073741824;
      else if (v < -66'sd1073741824)
         r = -32'sd1073741824;
      else
         r = v[31:0];
      return r;
   endfunction

   // Saturate to int32
   function automatic logic signed [31:0] sat_i32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647)
         r = 32'sh7fffffff;
      else if (v < -66'sd2147483648)
         r = 32'sh80000000;
      else
         r = v[31:0];
      return r;
   endfunction

   // Row and column of a row-major 3x3 entry
   function automatic logic [1:0] row_of(input logic [3:0] e);
      logic [1:0] r;
      case (e)
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd3, 4'd4, 4'd5: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] col_of(input logic [3:0] e);
      logic [1:0] c;
      case (e)
         4'd0, 4'd3, 4'd6: c = 2'd0;
         4'd1, 4'd4, 4'd7: c = 2'd1;
         default:          c = 2'd2;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

@@ rtl/fkjt_cordic.sv @@
// Sine/cosine unit: angle fold, degree-to-radian scaling, 30 CORDIC rotations.
// Depends on fkjt_pkg.
`default_nettype none
module fkjt_cordic (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [15:0]   angle,
   output fkjt_pkg::sincos_type result
);
   import fkjt_pkg::*;

   cor_phase_type phase_ff, phase_in;
   logic [4:0]          it_ff, it_in;
   logic signed [15:0]  a_ff, a_in;
   logic                neg_ff, neg_in;
   logic signed [ZW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   sincos_type          res_ff, res_in;

   logic signed [17:0]  wrap_w;
   logic signed [50:0]  ang_prod_w;
   logic signed [50:0]  ang_rnd_w;
   logic signed [ZW-1:0] atan_w;
   logic signed [ZW-1:0] xs_w, ys_w;
   logic signed [31:0]  xc_w, yc_w;

   // Wrap into one turn, fold into a half turn
   always_comb begin
      wrap_w = 18'(angle);
      neg_in = 1'b0;
      if (wrap_w > HALF_TURN)
         wrap_w = wrap_w - FULL_TURN;
      if (wrap_w < -HALF_TURN)
         wrap_w = wrap_w + FULL_TURN;
      if (wrap_w > QUARTER_TURN) begin
         wrap_w = wrap_w - HALF_TURN;
         neg_in = 1'b1;
      end else if (wrap_w < -QUARTER_TURN) begin
         wrap_w = wrap_w + HALF_TURN;
         neg_in = 1'b1;
      end
      a_in = wrap_w[15:0];
   end

   assign ang_prod_w = 51'(a_ff) * 51'(DEG_TO_RAD_Q46);
   assign ang_rnd_w  = (ang_prod_w + 51'sd32768) >>> 16;
   assign atan_w     = $signed(ZW'(atan_q30(it_ff)));
   assign xs_w       = x_ff >>> it_ff;
   assign ys_w       = y_ff >>> it_ff;
   assign xc_w       = clamp_q30(66'(x_ff));
   assign yc_w       = clamp_q30(66'(y_ff));

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         COR_IDLE:   if (start) phase_in = COR_ANGLE;
         COR_ANGLE:  phase_in = COR_ITER;
         COR_ITER:   if (it_ff == LAST_ITER) phase_in = COR_FINISH;
         COR_FINISH: phase_in = COR_IDLE;
         default:    phase_in = COR_IDLE;
      endcase
   end

   // Datapath next values
   always_comb begin
      it_in  = it_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      res_in = res_ff;
      res_in.done = 1'b0;
      case (phase_ff)
         COR_ANGLE: begin
            z_in  = ang_rnd_w[ZW-1:0];
            x_in  = CORDIC_K;
            y_in  = '0;
            it_in = '0;
         end
         COR_ITER: begin
            it_in = it_ff + 5'd1;
            if (z_ff >= 0) begin
               x_in = x_ff - ys_w;
               y_in = y_ff + xs_w;
               z_in = z_ff - atan_w;
            end else begin
               x_in = x_ff + ys_w;
               y_in = y_ff - xs_w;
               z_in = z_ff + atan_w;
            end
         end
         COR_FINISH: begin
            res_in.done = 1'b1;
            res_in.cos  = neg_ff ? -xc_w : xc_w;
            res_in.sin  = neg_ff ? -yc_w : yc_w;
         end
         default: ;
      endcase
   end

   // Phase and done clear on reset; datapath runs free
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= COR_IDLE;
         res_ff.done <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         res_ff.done <= res_in.done;
      end
      if (phase_ff == COR_IDLE && start) begin
         a_ff   <= a_in;
         neg_ff <= neg_in;
      end
      it_ff      <= it_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      res_ff.sin <= res_in.sin;
      res_ff.cos <= res_in.cos;
   end

   assign result = res_ff;

endmodule
`default_nettype wire

@@ rtl/forward_kinematics_joint_tree.sv @@
// Top level: joint tree forward kinematics with a world transform memory.
// Depends on fkjt_pkg and fkjt_cordic.
//
//   channel | ports                         | beat
//   --------+-------------------------------+-------------------------------
//   request | req_valid req_stall req_data  | one joint
//   result  | rsp_valid rsp_stall rsp_data  | world rotation and position
//
// A joint runs from a root with no rotation up to a child with a general
// axis, which passes the CORDIC loop, the axis-angle matrix through the
// shared multiplier, 12 parent reads and the multiply-adds, then 12 words
// written back to the same memory. Reset is synchronous; the memory holds no
// reset value, only the joint counter and control clear. A stalled result
// holds; the next joint may be accepted while it waits and is finished
// through write-back, then waits in the output state.
`default_nettype none
module forward_kinematics_joint_tree #(
   parameter int MAX_JOINTS = fkjt_pkg::MAX_JOINTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fkjt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fkjt_pkg::rsp_type rsp_data
);
   import fkjt_pkg::*;

   localparam int AW    = $clog2(MAX_JOINTS);
   localparam int PW    = (AW > 5) ? AW : 5;
   localparam int MA    = AW + 4;
   localparam int DEPTH = MAX_JOINTS * 16;
   localparam int TW    = 38;

   // Control
   fkjt_state_type state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [4:0]    rstep_ff, rstep_in;
   logic          phase_ff, phase_in;
   logic [3:0]    ld_ff, ld_in;
   logic [3:0]    wr_ff, wr_in;
   logic [1:0]    ci_ff, ci_in, cj_ff, cj_in, ck_ff, ck_in;
   logic          issue_ff, issue_in;
   logic          dv_ff, dv_in, dfirst_ff, dfirst_in, dlast_ff, dlast_in;
   logic [1:0]    di_ff, di_in, dj_ff, dj_in;

   // Datapath
   req_type            item_ff;
   logic [AW-1:0]      idx_ff, par_ff;
   logic               has_par_ff;
   logic signed [31:0] s_ff, c_ff;
   logic signed [31:0] rl_ff [9];
   logic signed [TW-1:0] tmp_ff [9];
   logic signed [31:0] rp_ff [12];
   logic signed [31:0] rw_ff [12];
   logic signed [64:0] prod_ff;
   logic signed [65:0] acc_ff;
   rsp_type            rsp_ff;

   logic               acc_req, out_free, hp_w, principal_w;
   logic [PW-1:0]      par_ext_w, cnt_ext_w;
   logic signed [32:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [32:0] t_w;
   logic signed [15:0] ax_w [3];
   logic signed [31:0] off_w [3];
   logic [3:0]         re_w;
   logic [1:0]         rk_w;
   logic signed [64:0] r28_w, r14_w;
   logic signed [TW-1:0] su_w, c_tw;
   logic signed [65:0] sum_w, r30_w;
   sincos_type         cor_res;

   // Memory: 16 words per joint, rotation in 0..8, position in 9..11
   logic [31:0]   mem [DEPTH];
   logic          rd_en, wr_en;
   logic [MA-1:0] rd_addr, wr_addr;
   logic [31:0]   wr_data, rd_data_ff;

   fkjt_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (acc_req && req_data.revolute),
      .angle  (req_data.angle),
      .result (cor_res)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign acc_req   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign par_ext_w = PW'(req_data.parent_index);
   assign cnt_ext_w = PW'(cnt_ff);
   assign hp_w      = req_data.has_parent && (par_ext_w < cnt_ext_w);

   assign ax_w[0]  = item_ff.axis_x;
   assign ax_w[1]  = item_ff.axis_y;
   assign ax_w[2]  = item_ff.axis_z;
   assign off_w[0] = item_ff.offset_x;
   assign off_w[1] = item_ff.offset_y;
   assign off_w[2] = item_ff.offset_z;

   assign principal_w =
      (item_ff.axis_x == AXIS_ONE && item_ff.axis_y == 0 && item_ff.axis_z == 0) ||
      (item_ff.axis_x == 0 && item_ff.axis_y == AXIS_ONE && item_ff.axis_z == 0) ||
      (item_ff.axis_x == 0 && item_ff.axis_y == 0 && item_ff.axis_z == AXIS_ONE);

   // Axis-angle step decode
   always_comb begin
      if (rstep_ff < 5'd9)
         re_w = rstep_ff[3:0];
      else
         re_w = 4'(rstep_ff - 5'd9);
      rk_w = 2'(rstep_ff - 5'd18);
   end

   assign t_w   = 33'(ONE_Q30) - 33'(c_ff);
   assign c_tw  = TW'(c_ff);
   assign r28_w = (prod_ff + 65'sd134217728) >>> 28;
   assign r14_w = (prod_ff + 65'sd8192) >>> 14;
   assign su_w  = $signed(r14_w[TW-1:0]);
   assign sum_w = (dfirst_ff ? 66'sd0 : acc_ff) + 66'(prod_ff);
   assign r30_w = (sum_w + 66'sd536870912) >>> 30;

   // Shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_RODR: begin
            if (rstep_ff < 5'd9) begin
               mul_a = 33'(ax_w[row_of(re_w)]);
               mul_b = 32'(ax_w[col_of(re_w)]);
            end else if (rstep_ff < 5'd18) begin
               mul_a = t_w;
               mul_b = tmp_ff[re_w][31:0];
            end else begin
               mul_a = 33'(s_ff);
               mul_b = 32'(ax_w[rk_w]);
            end
         end
         ST_COMPOSE: begin
            mul_a = 33'(rp_ff[4'(ci_ff) * 4'd3 + 4'(ck_ff)]);
            if (cj_ff == 2'd3)
               mul_b = off_w[ck_ff];
            else
               mul_b = rl_ff[4'(ck_ff) * 4'd3 + 4'(cj_ff)];
         end
         default: ;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (acc_req) begin
               if (req_data.revolute)
                  state_in = ST_CORDIC;
               else if (hp_w)
                  state_in = ST_LOAD;
               else
                  state_in = ST_ROOT;
            end
         ST_CORDIC:
            if (cor_res.done) begin
               if (!principal_w)
                  state_in = ST_RODR;
               else if (has_par_ff)
                  state_in = ST_LOAD;
               else
                  state_in = ST_ROOT;
            end
         ST_RODR:
            if (rstep_ff == 5'd20 && phase_ff) state_in = ST_RCLAMP;
         ST_RCLAMP:
            state_in = has_par_ff ? ST_LOAD : ST_ROOT;
         ST_LOAD:
            if (ld_ff == 4'd12) state_in = ST_COMPOSE;
         ST_COMPOSE:
            if (dv_ff && dlast_ff && di_ff == 2'd2 && dj_ff == 2'd3) state_in = ST_WRITE;
         ST_ROOT:
            state_in = ST_WRITE;
         ST_WRITE:
            if (wr_ff == 4'd11) state_in = ST_OUTPUT;
         ST_OUTPUT:
            if (out_free) state_in = ST_IDLE;
         default:
            state_in = ST_IDLE;
      endcase
   end

   // Counters and handshake outputs
   always_comb begin
      cnt_in = cnt_ff;
      if (acc_req) begin
         if (req_data.last_joint || cnt_ff == AW'(MAX_JOINTS - 1))
            cnt_in = '0;
         else
            cnt_in = cnt_ff + AW'(1);
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == ST_OUTPUT && out_free)
         rsp_valid_in = 1'b1;

      phase_in = (state_ff == ST_RODR) ? !phase_ff : 1'b0;
      rstep_in = (state_ff == ST_RODR) ? rstep_ff + 5'(phase_ff) : 5'd0;
      ld_in    = (state_ff == ST_LOAD) ? ld_ff + 4'd1 : 4'd0;
      wr_in    = (state_ff == ST_WRITE) ? wr_ff + 4'd1 : 4'd0;

      // Multiply-add issue: row, column (3 = position), term
      ci_in    = ci_ff;
      cj_in    = cj_ff;
      ck_in    = ck_ff;
      issue_in = issue_ff;
      if (state_ff != ST_COMPOSE) begin
         ci_in    = '0;
         cj_in    = '0;
         ck_in    = '0;
         issue_in = 1'b1;
      end else if (issue_ff) begin
         if (ck_ff == 2'd2) begin
            ck_in = '0;
            if (cj_ff == 2'd3) begin
               cj_in = '0;
               if (ci_ff == 2'd2)
                  issue_in = 1'b0;
               else
                  ci_in = ci_ff + 2'd1;
            end else begin
               cj_in = cj_ff + 2'd1;
            end
         end else begin
            ck_in = ck_ff + 2'd1;
         end
      end
      dv_in     = (state_ff == ST_COMPOSE) && issue_ff;
      dfirst_in = (ck_ff == 2'd0);
      dlast_in  = (ck_ff == 2'd2);
      di_in     = ci_ff;
      dj_in     = cj_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rstep_ff     <= '0;
         phase_ff     <= 1'b0;
         ld_ff        <= '0;
         wr_ff        <= '0;
         ci_ff        <= '0;
         cj_ff        <= '0;
         ck_ff        <= '0;
         issue_ff     <= 1'b1;
         dv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rstep_ff     <= rstep_in;
         phase_ff     <= phase_in;
         ld_ff        <= ld_in;
         wr_ff        <= wr_in;
         ci_ff        <= ci_in;
         cj_ff        <= cj_in;
         ck_ff        <= ck_in;
         issue_ff     <= issue_in;
         dv_ff        <= dv_in;
      end
   end

   // Memory ports
   assign rd_en   = (state_ff == ST_LOAD) && (ld_ff < 4'd12);
   assign rd_addr = {par_ff, ld_ff};
   assign wr_en   = (state_ff == ST_WRITE);
   assign wr_addr = {idx_ff, wr_ff};
   assign wr_data = rw_ff[wr_ff];

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      if (rd_en)
         rd_data_ff <= mem[rd_addr];
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      prod_ff   <= 65'(mul_a) * 65'(mul_b);
      dfirst_ff <= dfirst_in;
      dlast_ff  <= dlast_in;
      di_ff     <= di_in;
      dj_ff     <= dj_in;
      case (state_ff)
         ST_IDLE:
            if (acc_req) begin
               item_ff    <= req_data;
               idx_ff     <= cnt_ff;
               par_ff     <= par_ext_w[AW-1:0];
               has_par_ff <= hp_w;
               for (int e = 0; e < 9; e++)
                  rl_ff[e] <= (e % 4 == 0) ? 32'(ONE_Q30) : 32'sd0;
            end
         ST_CORDIC:
            if (cor_res.done) begin
               s_ff <= cor_res.sin;
               c_ff <= cor_res.cos;
               if (item_ff.axis_x == AXIS_ONE) begin
                  rl_ff[4] <= cor_res.cos;
                  rl_ff[5] <= -cor_res.sin;
                  rl_ff[7] <= cor_res.sin;
                  rl_ff[8] <= cor_res.cos;
               end else if (item_ff.axis_y == AXIS_ONE) begin
                  rl_ff[0] <= cor_res.cos;
                  rl_ff[2] <= cor_res.sin;
                  rl_ff[6] <= -cor_res.sin;
                  rl_ff[8] <= cor_res.cos;
               end else begin
                  rl_ff[0] <= cor_res.cos;
                  rl_ff[1] <= -cor_res.sin;
                  rl_ff[3] <= cor_res.sin;
                  rl_ff[4] <= cor_res.cos;
               end
            end
         // Axis-angle matrix: u u^T, then (1 - c) scale plus c, then sine terms
         ST_RODR:
            if (phase_ff) begin
               if (rstep_ff < 5'd9) begin
                  tmp_ff[re_w] <= prod_ff[TW-1:0];
               end else if (rstep_ff < 5'd18) begin
                  if (re_w == 4'd0 || re_w == 4'd4 || re_w == 4'd8)
                     tmp_ff[re_w] <= $signed(r28_w[TW-1:0]) + c_tw;
                  else
                     tmp_ff[re_w] <= r28_w[TW-1:0];
               end else begin
                  case (rk_w)
                     2'd0: begin
                        tmp_ff[5] <= tmp_ff[5] - su_w;
                        tmp_ff[7] <= tmp_ff[7] + su_w;
                     end
                     2'd1: begin
                        tmp_ff[2] <= tmp_ff[2] + su_w;
                        tmp_ff[6] <= tmp_ff[6] - su_w;
                     end
                     default: begin
                        tmp_ff[1] <= tmp_ff[1] - su_w;
                        tmp_ff[3] <= tmp_ff[3] + su_w;
                     end
                  endcase
               end
            end
         ST_RCLAMP:
            for (int e = 0; e < 9; e++)
               rl_ff[e] <= clamp_q30(66'(tmp_ff[e]));
         ST_LOAD:
            if (ld_ff != 4'd0)
               rp_ff[4'(ld_ff - 4'd1)] <= rd_data_ff;
         // Parent transform times local transform, one product a cycle
         ST_COMPOSE:
            if (dv_ff) begin
               if (dlast_ff) begin
                  if (dj_ff == 2'd3)
                     rw_ff[4'd9 + 4'(di_ff)] <=
                        sat_i32(r30_w + 66'(rp_ff[4'd9 + 4'(di_ff)]));
                  else
                     rw_ff[4'(di_ff) * 4'd3 + 4'(dj_ff)] <= clamp_q30(r30_w);
               end else begin
                  acc_ff <= sum_w;
               end
            end
         ST_ROOT: begin
            for (int e = 0; e < 9; e++)
               rw_ff[e] <= rl_ff[e];
            rw_ff[9]  <= item_ff.offset_x;
            rw_ff[10] <= item_ff.offset_y;
            rw_ff[11] <= item_ff.offset_z;
         end
         ST_OUTPUT:
            if (out_free) begin
               rsp_ff.r00   <= rw_ff[0];
               rsp_ff.r01   <= rw_ff[1];
               rsp_ff.r02   <= rw_ff[2];
               rsp_ff.r10   <= rw_ff[3];
               rsp_ff.r11   <= rw_ff[4];
               rsp_ff.r12   <= rw_ff[5];
               rsp_ff.r20   <= rw_ff[6];
               rsp_ff.r21   <= rw_ff[7];
               rsp_ff.r22   <= rw_ff[8];
               rsp_ff.pos_x <= rw_ff[9];
               rsp_ff.pos_y <= rw_ff[10];
               rsp_ff.pos_z <= rw_ff[11];
            end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // The sine/cosine unit only finishes while the sequencer waits for it
   a_cordic_done: assert property (@(posedge clock) disable iff (reset)
      cor_res.done |-> state_ff == ST_CORDIC)
      else $error("sine/cosine result outside its wait state");

   // Parent reads only touch joints written earlier in the pass
   a_parent_read: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> par_ff < idx_ff)
      else $error("parent read at or above current joint");

   // A result appears only after write-back completed
   a_result_order: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUTPUT)
      else $error("result raised outside output state");

   // Joint counter stays inside the store
   a_counter_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= AW'(MAX_JOINTS - 1))
      else $error("joint counter out of range");
`endif

endmodule
`default_nettype wire

@@ tb/forward_kinematics_joint_tree_tb.sv @@
// Testbench for forward_kinematics_joint_tree: random and directed joints, scoreboard check.
// Depends on fkjt_pkg and the RTL top level; self-contained otherwise.
`timescale 1ns / 1ps
`default_nettype none
module forward_kinematics_joint_tree_tb;
   import fkjt_pkg::*;

   localparam int NJ = 32;
   localparam int N_RANDOM = 1750;
   localparam int CYCLE_LIMIT = 2000000;
   localparam longint Q30 = 64'sd1073741824;
   localparam longint KSTART = 64'sd652032874;
   localparam longint RADS = 64'sd9595048166;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   int cycle_count = 0;
   bit hold_rsp = 1'b0;
   bit stim_done = 1'b0;

   forward_kinematics_joint_tree dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------- pose predictor ----------------
   function automatic longint fshr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint rshr(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint arctan_step(int i);
      longint t[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149};
      if (i < 10) return t[i];
      return 64'sd1 <<< (30 - i);
   endfunction

   class joint_scoreboard;
      longint rot_mem[NJ][9];
      longint pos_mem[NJ][3];
      int slot;
      rsp_type pending[$];
      int mismatches;

      function new();
         slot = 0;
         mismatches = 0;
      endfunction

      function void sine_cosine(longint a, output longint s, output longint c);
         bit flip;
         longint x, y, z, t;
         flip = 0;
         x = KSTART;
         y = 0;
         if (a > 23040) a -= 46080;
         if (a < -23040) a += 46080;
         if (a > 11520) begin a -= 23040; flip = 1; end
         else if (a < -11520) begin a += 23040; flip = 1; end
         z = rshr(a * RADS, 16);
         for (int i = 0; i < 30; i++) begin
            if (z >= 0) begin
               t = x - fshr(y, i); y = y + fshr(x, i); z -= arctan_step(i);
            end else begin
               t = x + fshr(y, i); y = y - fshr(x, i); z += arctan_step(i);
            end
            x = t;
         end
         x = clip(x, -Q30, Q30);
         y = clip(y, -Q30, Q30);
         c = flip ? -x : x;
         s = flip ? -y : y;
      endfunction

      function void axis_rotation(req_type j, output longint r[9]);
         longint s, c, t, u[3], su[3];
         for (int i = 0; i < 9; i++) r[i] = (i % 4 == 0) ? Q30 : 0;
         if (!j.revolute) return;
         sine_cosine(longint'(j.angle), s, c);
         u[0] = j.axis_x; u[1] = j.axis_y; u[2] = j.axis_z;
         if (u[0] == 16384 && u[1] == 0 && u[2] == 0) begin
            r[4] = c; r[5] = -s; r[7] = s; r[8] = c; return;
         end
         if (u[0] == 0 && u[1] == 16384 && u[2] == 0) begin
            r[0] = c; r[2] = s; r[6] = -s; r[8] = c; return;
         end
         if (u[0] == 0 && u[1] == 0 && u[2] == 16384) begin
            r[0] = c; r[1] = -s; r[3] = s; r[4] = c; return;
         end
         t = Q30 - c;
         for (int i = 0; i < 3; i++) su[i] = rshr(s * u[i], 14);
         for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
               r[i*3+k] = rshr(t * (u[i] * u[k]), 28) + (i == k ? c : 0);
         r[1] -= su[2]; r[3] += su[2];
         r[2] += su[1]; r[6] -= su[1];
         r[5] -= su[0]; r[7] += su[0];
         for (int i = 0; i < 9; i++) r[i] = clip(r[i], -Q30, Q30);
      endfunction

      // Accepted joint beat: compute and queue its world pose.
      function void note_joint(req_type j);
         longint rl[9], rw[9], pw[3], off[3], acc;
         int p;
         rsp_type e;
         bit linked;
         p = j.parent_index;
         linked = j.has_parent && (p < slot);
         off[0] = j.offset_x; off[1] = j.offset_y; off[2] = j.offset_z;
         axis_rotation(j, rl);
         if (linked) begin
            for (int i = 0; i < 3; i++) begin
               for (int k = 0; k < 3; k++) begin
                  acc = 0;
                  for (int m = 0; m < 3; m++) acc += rot_mem[p][i*3+m] * rl[m*3+k];
                  rw[i*3+k] = clip(rshr(acc, 30), -Q30, Q30);
               end
               acc = 0;
               for (int m = 0; m < 3; m++) acc += rot_mem[p][i*3+m] * off[m];
               pw[i] = clip(rshr(acc, 30) + pos_mem[p][i],
                            -64'sd2147483648, 64'sd2147483647);
            end
         end else begin
            rw = rl;
            pw = off;
         end
         for (int i = 0; i < 9; i++) rot_mem[slot][i] = rw[i];
         for (int i = 0; i < 3; i++) pos_mem[slot][i] = pw[i];
         e = {32'(rw[0]), 32'(rw[1]), 32'(rw[2]), 32'(rw[3]), 32'(rw[4]),
              32'(rw[5]), 32'(rw[6]), 32'(rw[7]), 32'(rw[8]),
              32'(pw[0]), 32'(pw[1]), 32'(pw[2])};
         pending = {pending, e};
         slot = j.last_joint ? 0 : (slot + 1) % NJ;
      endfunction

      // Accepted result beat: compare against the oldest pose.
      function void check_pose(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
            return;
         end
         e = pending.pop_front();
         for (int f = 0; f < 12; f++) begin
            if (e[383 - 32*f -: 32] !== got[383 - 32*f -: 32]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("field %0d: expected %0d actual %0d", f,
                           $signed(e[383 - 32*f -: 32]), $signed(got[383 - 32*f -: 32]));
            end
         end
      endfunction
   endclass

   joint_scoreboard board = new();

   // Cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Monitor both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_joint(req_data);
         if (rsp_valid && !rsp_stall) board.check_pose(rsp_data);
      end
   end

   // Result side: random stall per beat, or a long hold-off
   initial begin : rsp_side
      int w;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end else begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (w > 0) begin
               rsp_stall <= 1'b1;
               repeat (w) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            @(posedge clock);
            while (!rsp_valid && !hold_rsp) @(posedge clock);
         end
      end
   end

   function automatic logic signed [15:0] pick_axis();
      case ($urandom_range(0, 5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sd0;
         3: return 16'($urandom_range(0, 32767)) - 16'sd16384;
         4: return 16'($urandom);
         default: return 16'sd11585;
      endcase
   endfunction

   function automatic req_type random_joint(int pos, bit last);
      req_type j;
      j = '0;
      j.has_parent = $urandom_range(0, 7) != 0;
      j.parent_index = (pos > 0 && $urandom_range(0, 7) != 0) ?
                       5'($urandom_range(0, pos - 1)) : 5'($urandom);
      j.revolute = $urandom_range(0, 4) != 0;
      case ($urandom_range(0, 3))
         0: begin j.offset_x = $urandom; j.offset_y = $urandom; j.offset_z = $urandom; end
         default: begin
            j.offset_x = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            j.offset_y = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            j.offset_z = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
         end
      endcase
      case ($urandom_range(0, 3))
         0: begin j.axis_x = 16384; j.axis_y = 0; j.axis_z = 0; end
         1: begin j.axis_x = 0; j.axis_y = 16384; j.axis_z = 0; end
         2: begin j.axis_x = 0; j.axis_y = 0; j.axis_z = 16384; end
         default: begin j.axis_x = pick_axis(); j.axis_y = pick_axis(); j.axis_z = pick_axis(); end
      endcase
      j.angle = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                16'($urandom_range(0, 46080)) - 16'sd23040;
      j.last_joint = last;
      return j;
   endfunction

   // Offer one joint beat after a random gap; valid stays up until the next gap
   task automatic send_joint(req_type j);
      int w;
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (w > 0) begin
         req_valid <= 1'b0;
         repeat (w) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= j;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_back_to_back(req_type j);
      req_valid <= 1'b1;
      req_data <= j;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin : req_side
      req_type j;
      int pos, len;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed chain: extremes, principal and negative axes, wrap, saturation
      pos = 0;
      for (int d = 0; d < 22; d++) begin
         j = '0;
         j.has_parent = d != 0;
         j.parent_index = (d == 5) ? 5'd31 : 5'(d == 0 ? 0 : d - 1);
         j.revolute = d % 7 != 6;
         j.offset_x = (d % 4 == 1) ? 32'sh7fffffff : 32'sh00010000;
         j.offset_y = (d % 4 == 2) ? 32'sh80000000 : -32'sh00008000;
         j.offset_z = (d % 4 == 3) ? 32'sh7fffffff : 32'sh0;
         j.axis_x = (d % 3 == 0) ? 16'sd16384 : ((d % 5 == 0) ? -16'sd16384 : 16'sd9459);
         j.axis_y = (d % 3 == 1) ? 16'sd16384 : ((d == 10) ? 16'sh7fff : 16'sd0);
         j.axis_z = (d % 3 == 2) ? 16'sd16384 : ((d == 11) ? 16'sh8000 : 16'sd0);
         case (d % 6)
            0: j.angle = 16'sd23040;
            1: j.angle = -16'sd23040;
            2: j.angle = 16'sh7fff;
            3: j.angle = 16'sh8000;
            4: j.angle = 16'sd11520;
            default: j.angle = 16'sd0;
         endcase
         j.last_joint = d == 21;
         send_joint(j);
      end
      wait_drained();

      // Random passes; one stretch of joints runs with the result side held off
      pos = 0;
      len = $urandom_range(2, 32);
      for (int n = 0; n < N_RANDOM; n++) begin
         j = random_joint(pos, (pos == len - 1) || ($urandom_range(0, 63) == 0));
         if (n == 300) begin
            hold_rsp = 1'b1;
            fork
               begin repeat (600) @(posedge clock); hold_rsp = 1'b0; end
            join_none
         end
         if (n >= 300 && n < 310) send_back_to_back(j);
         else send_joint(j);
         if (j.last_joint) begin
            pos = 0;
            len = $urandom_range(2, 32);
         end else pos = (pos + 1) % NJ;
         if (n == 900) wait_drained();
      end
      wait_drained();
      repeat (200) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
